>>> hw/rtl/f2c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// f2c_pkg
// Shared types and constants of the Frenet-to-Cartesian converter.
// ----------------------------------------------------------------------------
package f2c_pkg;

	localparam int unsigned MAX_WP_DEF = 256;
	localparam int unsigned CFG_W      = 9;
	localparam int unsigned IDX_W      = 8;
	localparam int unsigned DAT_W      = 32;
	localparam int unsigned ENTRY_W    = 3 * DAT_W;

	typedef enum logic {
		OPC_LOAD  = 1'b0,
		OPC_QUERY = 1'b1
	} f2c_opc_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SRCH,
		ST_SCHK,
		ST_PREV,
		ST_NEXT,
		ST_DIFF,
		ST_SQ1,
		ST_SQ2,
		ST_SQ3,
		ST_SQCHK,
		ST_NORM,
		ST_SQRT,
		ST_SQRTW,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_DIV,
		ST_DIVW,
		ST_SUM,
		ST_OUT
	} f2c_state_t;

	typedef enum logic {
		IOP_SQRT = 1'b0,
		IOP_DIV  = 1'b1
	} f2c_iop_t;

	typedef struct packed {
		logic     start;
		f2c_iop_t op;
	} f2c_iter_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/f2c_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// f2c channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface f2c_req_if import f2c_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    opcode;
	logic [IDX_W-1:0]        wp_index;
	logic [DAT_W-1:0]        wp_s;
	logic signed [DAT_W-1:0] wp_x;
	logic signed [DAT_W-1:0] wp_y;
	logic [DAT_W-1:0]        query_s;
	logic signed [DAT_W-1:0] query_d;

	modport source (output valid, opcode, wp_index, wp_s, wp_x, wp_y, query_s, query_d,
		input ready);
	modport sink (input valid, opcode, wp_index, wp_s, wp_x, wp_y, query_s, query_d,
		output ready);
endinterface

interface f2c_rsp_if import f2c_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [DAT_W-1:0] out_x;
	logic signed [DAT_W-1:0] out_y;
	logic [IDX_W-1:0]        segment_start;

	modport source (output valid, out_x, out_y, segment_start, input ready);
	modport sink (input valid, out_x, out_y, segment_start, output ready);
endinterface

interface f2c_cfg_if import f2c_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] num_waypoints;

	modport source (output valid, num_waypoints, input ready);
	modport sink (input valid, num_waypoints, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/f2c_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// f2c_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module f2c_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/f2c_iter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// f2c_iter
// Shared iterative unit: restoring square root (64 steps) and restoring
// 128/63-bit division (128 steps plus a round-half-up step).
// ----------------------------------------------------------------------------
module f2c_iter import f2c_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire f2c_iter_ctl_t ctl,
	input  wire logic [127:0]  opa,
	input  wire logic [62:0]   den,
	output logic               done,
	output logic [63:0]        res
);
	logic         busy_q, rnd_q, done_q;
	f2c_iop_t     op_q;
	logic [6:0]   cnt_q;
	logic [127:0] sh_q;
	logic [65:0]  rem_q;
	logic [63:0]  q_q;
	logic [62:0]  den_q;

	logic [65:0] cand, trial;
	logic [66:0] diff;
	logic        ge, last, rnd_up;
	logic [63:0] r64, half;

	always_comb begin
		if (op_q == IOP_SQRT) begin
			cand  = {rem_q[63:0], sh_q[127:126]};
			trial = {1'b0, q_q[62:0], 2'b01};
			last  = (cnt_q == 7'd63);
		end else begin
			cand  = {rem_q[64:0], sh_q[127]};
			trial = {3'b000, den_q};
			last  = (cnt_q == 7'd127);
		end
		diff   = {1'b0, cand} - {1'b0, trial};
		ge     = ~diff[66];
		r64    = {1'b0, rem_q[62:0]};
		half   = {1'b0, den_q} - r64;
		rnd_up = (r64 >= half);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
				if (op_q == IOP_DIV) begin
					rnd_q <= 1'b1;
				end else begin
					done_q <= 1'b1;
				end
			end else if (rnd_q) begin
				rnd_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q  <= ctl.op;
			sh_q  <= opa;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[65:0] : cand;
			sh_q  <= (op_q == IOP_SQRT) ? {sh_q[125:0], 2'b00} : {sh_q[126:0], 1'b0};
			q_q   <= {q_q[62:0], ge};
			cnt_q <= cnt_q + 7'd1;
		end else if (rnd_q && rnd_up) begin
			q_q <= q_q + 64'd1;
		end
	end

	assign done = done_q;
	assign res  = q_q;
endmodule
`default_nettype wire

>>> hw/rtl/frenet_to_cartesian.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frenet_to_cartesian
// Converts (s, d) track coordinates to (x, y) over a closed waypoint table.
// ----------------------------------------------------------------------------
// Load: the entry is written when accepted and the block stays ready; no response.
// Query: a search over the table, at most 62 normalize steps, a square root and
//   two divisions (x pass, y pass) on the shared sqrt/divide unit, then the
//   result is valid. A zero-length segment skips root and divisions.
// One item at a time: the request side is not ready until the result transfers.
// Reset clears control and sets num_waypoints to 2; the table is not cleared.
module frenet_to_cartesian import f2c_pkg::*; #(
	parameter int unsigned MAX_WAYPOINTS = MAX_WP_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	f2c_req_if.sink   req,
	f2c_rsp_if.source rsp,
	f2c_cfg_if.sink   cfg
);
	localparam int unsigned AW = $clog2(MAX_WAYPOINTS);
	localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);

	function automatic logic [31:0] mag33(input logic [32:0] v);
		logic [32:0] n;
		n = v[32] ? (~v + 33'd1) : v;
		return n[31:0];
	endfunction

	function automatic logic [31:0] sat37(input logic [36:0] v);
		if (v[36:31] == {6{v[36]}}) return v[31:0];
		return v[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	f2c_state_t state_q, state_d;

	logic [CW-1:0]  nwp_q, cnt_q;
	logic [AW-1:0]  prev_q, prev_d, nxt_d, raddr;
	logic [CW-1:0]  nxt_sum;
	logic [31:0]    qs_q, s0_q;
	logic [31:0]    d_q, x0_q, y0_q;
	logic [32:0]    seg_q, dx_q, dy_q;
	logic [63:0]    prod_q, m1_q;
	logic [65:0]    acc_q;
	logic [127:0]   v_q, num_q;
	logic [5:0]     f_q;
	logic [62:0]    lq_q;
	logic           pass_q, neg_q;
	logic [35:0]    offx_q, offy_q;
	logic [31:0]    ox_q, oy_q;
	logic [7:0]     seg_start_q;

	logic [ENTRY_W-1:0] rdata;
	logic               we;
	logic [31:0]        mul_a, mul_b;
	logic [31:0]        seg_m, dx_m, dy_m, d_m;
	logic               s1, s2;
	logic [65:0]        t1, t2, tsum, tmag;
	logic [35:0]        qoff;
	logic [31:0]        cfg32, cfg_cl;

	f2c_iter_ctl_t ictl;
	logic          idone;
	logic [63:0]   ires;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_comb begin
		cfg32  = 32'(cfg.num_waypoints);
		cfg_cl = cfg32;
		if (cfg32 < 32'd2) cfg_cl = 32'd2;
		if (cfg32 > 32'(MAX_WAYPOINTS)) cfg_cl = 32'(MAX_WAYPOINTS);
	end

	// ---------------- table ----------------
	assign we = (state_q == ST_IDLE) && req.valid && (req.opcode == OPC_LOAD)
		&& (32'(req.wp_index) < 32'(MAX_WAYPOINTS));

	f2c_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WAYPOINTS)) u_tbl (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(req.wp_index)),
		.wdata ({req.wp_s, req.wp_x, req.wp_y}),
		.raddr (raddr),
		.rdata (rdata)
	);

	f2c_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ictl),
		.opa    ((state_q == ST_DIV) ? num_q : v_q),
		.den    (lq_q),
		.done   (idone),
		.res    (ires)
	);

	// ---------------- index arithmetic ----------------
	always_comb begin
		prev_d  = (cnt_q == '0) ? '0 : AW'(cnt_q - CW'(1));
		nxt_sum = CW'(prev_q) + CW'(1);
		nxt_d   = (nxt_sum >= nwp_q) ? '0 : AW'(nxt_sum);
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (req.valid && req.opcode == OPC_QUERY) state_d = ST_SRCH;
			ST_SRCH:  state_d = (cnt_q < nwp_q) ? ST_SCHK : ST_PREV;
			ST_SCHK:  state_d = (qs_q > rdata[95:64]) ? ST_SRCH : ST_PREV;
			ST_PREV:  state_d = ST_NEXT;
			ST_NEXT:  state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_SQ1;
			ST_SQ1:   state_d = ST_SQ2;
			ST_SQ2:   state_d = ST_SQ3;
			ST_SQ3:   state_d = ST_SQCHK;
			ST_SQCHK: state_d = (acc_q == '0) ? ST_SUM : ST_NORM;
			ST_NORM:  if (v_q[127:124] != 4'd0) state_d = ST_SQRT;
			ST_SQRT:  state_d = ST_SQRTW;
			ST_SQRTW: if (idone) state_d = ST_P1;
			ST_P1:    state_d = ST_P2;
			ST_P2:    state_d = ST_P3;
			ST_P3:    state_d = ST_DIV;
			ST_DIV:   state_d = ST_DIVW;
			ST_DIVW:  if (idone) state_d = pass_q ? ST_SUM : ST_P1;
			ST_SUM:   state_d = ST_OUT;
			ST_OUT:   if (rsp.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ---------------- outputs of the sequencer ----------------
	always_comb begin
		req.ready  = (state_q == ST_IDLE);
		rsp.valid  = (state_q == ST_OUT);
		ictl.start = (state_q == ST_SQRT) || (state_q == ST_DIV);
		ictl.op    = (state_q == ST_DIV) ? IOP_DIV : IOP_SQRT;
		raddr      = AW'(cnt_q);
		mul_a      = dx_m;
		mul_b      = dx_m;
		unique case (state_q)
			ST_PREV: raddr = prev_d;
			ST_NEXT: raddr = nxt_d;
			ST_SQ2:  begin mul_a = dy_m; mul_b = dy_m; end
			ST_P1:   begin mul_a = seg_m; mul_b = pass_q ? dy_m : dx_m; end
			ST_P2:   begin mul_a = d_m; mul_b = pass_q ? dx_m : dy_m; end
			default: ;
		endcase
	end

	assign rsp.out_x         = ox_q;
	assign rsp.out_y         = oy_q;
	assign rsp.segment_start = seg_start_q;

	// ---------------- datapath ----------------
	always_comb begin
		seg_m = mag33(seg_q);
		dx_m  = mag33(dx_q);
		dy_m  = mag33(dy_q);
		d_m   = d_q[31] ? (~d_q + 32'd1) : d_q;
		// y pass works with -d: negative when d is positive
		s1    = seg_q[32] ^ (pass_q ? dy_q[32] : dx_q[32]);
		s2    = (pass_q ? (!d_q[31] && d_q != 32'd0) : d_q[31])
			^ (pass_q ? dx_q[32] : dy_q[32]);
		t1    = s1 ? (~{2'b00, m1_q} + 66'd1) : {2'b00, m1_q};
		t2    = s2 ? (~{2'b00, prod_q} + 66'd1) : {2'b00, prod_q};
		tsum  = t1 + t2;
		tmag  = tsum[65] ? (~tsum + 66'd1) : tsum;
		qoff  = neg_q ? (~{1'b0, ires[34:0]} + 36'd1) : {1'b0, ires[34:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nwp_q   <= CW'(2);
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) nwp_q <= CW'(cfg_cl);
			if (state_q == ST_IDLE) cnt_q <= '0;
			else if (state_q == ST_SCHK && qs_q > rdata[95:64]) cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				qs_q   <= req.query_s;
				d_q    <= req.query_d;
				pass_q <= 1'b0;
			end
			ST_PREV: prev_q <= prev_d;
			ST_NEXT: begin
				s0_q        <= rdata[95:64];
				x0_q        <= rdata[63:32];
				y0_q        <= rdata[31:0];
				seg_start_q <= 8'(prev_q);
			end
			ST_DIFF: begin
				seg_q <= {1'b0, qs_q} - {1'b0, s0_q};
				dx_q  <= {rdata[63], rdata[63:32]} - {x0_q[31], x0_q};
				dy_q  <= {rdata[31], rdata[31:0]} - {y0_q[31], y0_q};
			end
			ST_SQ2: acc_q <= {2'b00, prod_q};
			ST_SQ3: acc_q <= acc_q + {2'b00, prod_q};
			ST_SQCHK: begin
				v_q    <= 128'(acc_q);
				f_q    <= '0;
				// degenerate segment: heading +x
				offx_q <= {{3{seg_q[32]}}, seg_q};
				offy_q <= ~{{4{d_q[31]}}, d_q} + 36'd1;
			end
			ST_NORM: if (v_q[127:124] == 4'd0) begin
				v_q <= {v_q[125:0], 2'b00};
				f_q <= f_q + 6'd1;
			end
			ST_SQRTW: if (idone) lq_q <= ires[62:0];
			ST_P2:   m1_q <= prod_q;
			ST_P3: begin
				num_q <= 128'(tmag) << f_q;
				neg_q <= tsum[65];
			end
			ST_DIVW: if (idone) begin
				if (pass_q) offy_q <= qoff;
				else offx_q <= qoff;
				pass_q <= 1'b1;
			end
			ST_SUM: begin
				ox_q <= sat37({{5{x0_q[31]}}, x0_q} + {offx_q[35], offx_q});
				oy_q <= sat37({{5{y0_q[31]}}, y0_q} + {offy_q[35], offy_q});
			end
			default: ;
		endcase
	end

	// ---------------- assertions ----------------
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request taken while a result is pending");

	a_iter_done: assert property (@(posedge clk) disable iff (!arst_n)
		idone |-> (state_q == ST_SQRTW || state_q == ST_DIVW))
		else $error("iterative unit finished outside a wait state");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= nwp_q)
		else $error("search ran past the track");

	a_nwp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nwp_q >= CW'(2)) && (nwp_q <= CW'(MAX_WAYPOINTS)))
		else $error("waypoint count out of range");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.out_x)))
		else $error("result dropped before transfer");
endmodule
`default_nettype wire
